// ===== hdl/tgd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgd_pkg
// Shared types, constants and helper functions of the tilt gesture dimmer.
// ----------------------------------------------------------------------------
package tgd_pkg;

  localparam int TGD_TIMER_BITS = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TILT_TRIP         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_BAND       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_MS           = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DIRECTION_LOCK_MS = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BATTERY_OK_LEVEL  = 3'd4;

  // Configuration reset values.
  localparam int TILT_TRIP_RST         = 96;
  localparam int CENTER_BAND_RST       = 48;
  localparam int HOLD_MS_RST           = 1000;
  localparam int DIRECTION_LOCK_MS_RST = 1000;
  localparam int BATTERY_OK_LEVEL_RST  = 534;

  // Timing of the fades and of the manual steps, in milliseconds.
  localparam int FADE_UP_PERIOD      = 20;
  localparam int FADE_DN_SLOW_PERIOD = 20;
  localparam int FADE_DN_FAST_PERIOD = 4;
  localparam int STEP_UP_PERIOD      = 7;
  localparam int STEP_DN_PERIOD      = 10;

  // Level thresholds and step sizes.
  localparam int LEVEL_LOW_SAVED = 40;
  localparam int LEVEL_MID       = 75;
  localparam int LEVEL_HIGH      = 150;
  localparam int LEVEL_FLOOR     = 15;
  localparam int LEVEL_MAX       = 255;
  localparam int SAVED_LEVEL_RST = 50;
  localparam int FADE_UP_SMALL   = 1;
  localparam int FADE_UP_LARGE   = 3;
  localparam int FADE_DN_LARGE   = 10;
  localparam int STEP_DN_HIGH    = 3;
  localparam int STEP_DN_MID     = 2;
  localparam int STEP_DN_LOW     = 1;

  typedef enum logic [2:0] {
    DIR_NONE      = 3'd0,
    DIR_ROLL_POS  = 3'd1,
    DIR_ROLL_NEG  = 3'd2,
    DIR_PITCH_POS = 3'd3,
    DIR_PITCH_NEG = 3'd4
  } tgd_dir_t;

  typedef enum logic [1:0] {
    FADE_NONE,
    FADE_UP,
    FADE_DOWN
  } tgd_fade_t;

  typedef struct packed {
    logic [11:0] tilt_trip;
    logic [11:0] center_band;
    logic [15:0] hold_ms;
    logic [15:0] direction_lock_ms;
    logic [9:0]  battery_ok_level;
  } tgd_cfg_t;

  // Level state that the axis updates, the fades and the top level all touch.
  typedef struct packed {
    logic        ramping_up;
    logic        ramping_down;
    logic        level_adjusted;
    tgd_dir_t    last_direction;
    logic [7:0]  current_level;
    logic [7:0]  saved_level;
  } tgd_dim_t;

  typedef struct packed {
    logic     on_state;
    logic     away_from_center;
    logic     pending_off;
    logic     roll_tilted;
    logic     pitch_tilted;
    logic     was_unplugged;
    tgd_dim_t dim;
  } tgd_state_t;

  // Magnitude of a 13-bit signed angle, returned as 14 bits; the most negative code gives 4096.
  function automatic logic [13:0] tgd_mag(input logic signed [12:0] v);
    logic signed [13:0] v14;
    v14 = {v[12], v};
    return v[12] ? 14'(-v14) : 14'(v14);
  endfunction

  // Direction of a clear single-axis tilt, or the previous direction if none.
  function automatic tgd_dir_t tgd_dir_pick(input logic signed [12:0] r,
                                            input logic signed [12:0] p,
                                            input logic [11:0]        th,
                                            input tgd_dir_t           last);
    logic [13:0]        mr;
    logic [13:0]        mp;
    logic [13:0]        thu;
    logic signed [13:0] rs;
    logic signed [13:0] ps;
    logic signed [13:0] ths;
    tgd_dir_t           res;
    mr  = tgd_mag(r);
    mp  = tgd_mag(p);
    thu = {2'b00, th};
    rs  = {r[12], r};
    ps  = {p[12], p};
    ths = $signed({2'b00, th});
    if (mp <= thu && rs >= ths) begin
      res = DIR_ROLL_POS;
    end else if (mp <= thu && rs <= -ths) begin
      res = DIR_ROLL_NEG;
    end else if (mr <= thu && ps >= ths) begin
      res = DIR_PITCH_POS;
    end else if (mr <= thu && ps <= -ths) begin
      res = DIR_PITCH_NEG;
    end else begin
      res = last;
    end
    return res;
  endfunction

endpackage

// ===== hdl/tgd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tgd_cfg_regs
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
module tgd_cfg_regs import tgd_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [15:0]               wr_data,
  output tgd_cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tilt_trip         <= 12'(TILT_TRIP_RST);
      cfg.center_band       <= 12'(CENTER_BAND_RST);
      cfg.hold_ms           <= 16'(HOLD_MS_RST);
      cfg.direction_lock_ms <= 16'(DIRECTION_LOCK_MS_RST);
      cfg.battery_ok_level  <= 10'(BATTERY_OK_LEVEL_RST);
    end else if (wr_en) begin
      // Writes to unused indexes are dropped.
      unique case (wr_index)
        CFG_TILT_TRIP:         cfg.tilt_trip         <= wr_data[11:0];
        CFG_CENTER_BAND:       cfg.center_band       <= wr_data[11:0];
        CFG_HOLD_MS:           cfg.hold_ms           <= wr_data;
        CFG_DIRECTION_LOCK_MS: cfg.direction_lock_ms <= wr_data;
        CFG_BATTERY_OK_LEVEL:  cfg.battery_ok_level  <= wr_data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/tgd_axis.sv =====
// ----------------------------------------------------------------------------
// tgd_axis
// Tilt detection, hold timing and manual level stepping for one axis.
// ----------------------------------------------------------------------------
module tgd_axis import tgd_pkg::*; #(
  parameter int TIMER_BITS = TGD_TIMER_BITS
) (
  input  tgd_cfg_t               cfg,
  input  logic signed [12:0]     angle,
  input  logic signed [12:0]     roll,
  input  logic signed [12:0]     pitch,
  input  logic                   need_on,
  input  tgd_dir_t               dir_pos,
  input  tgd_dir_t               dir_neg,
  input  logic                   on_state,
  input  logic                   tilted_in,
  input  logic [TIMER_BITS-1:0]  hold_in,
  input  tgd_dim_t               dim_in,
  input  logic [TIMER_BITS-1:0]  adjust_in,
  input  logic [TIMER_BITS-1:0]  dirtime_in,
  output logic                   tilted_out,
  output logic [TIMER_BITS-1:0]  hold_out,
  output tgd_dim_t               dim_out,
  output logic [TIMER_BITS-1:0]  adjust_out,
  output logic [TIMER_BITS-1:0]  dirtime_out
);

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  logic signed [13:0] angle_s;
  logic signed [13:0] th_s;
  logic               is_pos;
  logic               is_neg;

  assign angle_s = {angle[12], angle};
  assign th_s    = $signed({2'b00, cfg.tilt_trip});
  assign is_pos  = angle_s >= th_s;
  assign is_neg  = angle_s <= -th_s;

  always_comb begin
    tilted_out  = tilted_in;
    hold_out    = hold_in;
    dim_out     = dim_in;
    adjust_out  = adjust_in;
    dirtime_out = dirtime_in;
    if (is_pos || is_neg) begin
      if (!tilted_in) begin
        hold_out               = '0;
        tilted_out             = 1'b1;
        dim_out.level_adjusted = 1'b0;
      end
      if (CW'(hold_out) >= CW'(cfg.hold_ms) && (on_state || !need_on)) begin
        // Tilting against the remembered direction dims; anything else brightens.
        if ((dim_in.last_direction == dir_pos && is_neg) ||
            (dim_in.last_direction == dir_neg && is_pos)) begin
          if (adjust_in >= TIMER_BITS'(STEP_DN_PERIOD)) begin
            adjust_out = '0;
            if (dim_in.current_level > 8'(LEVEL_FLOOR)) begin
              if (dim_in.current_level > 8'(LEVEL_HIGH)) begin
                dim_out.current_level = dim_in.current_level - 8'(STEP_DN_HIGH);
              end else if (dim_in.current_level > 8'(LEVEL_MID)) begin
                dim_out.current_level = dim_in.current_level - 8'(STEP_DN_MID);
              end else begin
                dim_out.current_level = dim_in.current_level - 8'(STEP_DN_LOW);
              end
              dim_out.saved_level = dim_out.current_level;
            end
          end
          dim_out.ramping_down   = 1'b1;
          dim_out.level_adjusted = 1'b1;
        end else begin
          if (adjust_in >= TIMER_BITS'(STEP_UP_PERIOD)) begin
            adjust_out = '0;
            if (dim_in.current_level < 8'(LEVEL_MAX)) begin
              dim_out.current_level = dim_in.current_level + 8'd1;
              dim_out.saved_level   = dim_out.current_level;
            end
          end
          if (CW'(dirtime_in) > CW'(cfg.direction_lock_ms)) begin
            dim_out.last_direction = tgd_dir_pick(roll, pitch, cfg.tilt_trip,
                                                  dim_in.last_direction);
            dirtime_out = '0;
          end
          dim_out.ramping_up = 1'b1;
        end
      end
    end else begin
      tilted_out = 1'b0;
    end
  end

endmodule

// ===== hdl/tgd_fade.sv =====
// ----------------------------------------------------------------------------
// tgd_fade
// Automatic fade toward the saved level or toward dark at stepped rates.
// ----------------------------------------------------------------------------
module tgd_fade import tgd_pkg::*; #(
  parameter int TIMER_BITS = TGD_TIMER_BITS
) (
  input  tgd_fade_t             mode,
  input  logic [7:0]            cur_in,
  input  logic [7:0]            saved,
  input  logic                  ramping_down,
  input  logic [TIMER_BITS-1:0] up_time_in,
  input  logic [TIMER_BITS-1:0] down_time_in,
  output logic [7:0]            cur_out,
  output logic [TIMER_BITS-1:0] up_time_out,
  output logic [TIMER_BITS-1:0] down_time_out
);

  logic                  saved_low;
  logic [8:0]            up_sum;
  logic [TIMER_BITS-1:0] down_period;

  assign saved_low   = saved < 8'(LEVEL_LOW_SAVED);
  assign up_sum      = {1'b0, cur_in} +
                       (saved_low ? 9'(FADE_UP_SMALL) : 9'(FADE_UP_LARGE));
  assign down_period = saved_low ? TIMER_BITS'(FADE_DN_SLOW_PERIOD)
                                 : TIMER_BITS'(FADE_DN_FAST_PERIOD);

  always_comb begin
    cur_out       = cur_in;
    up_time_out   = up_time_in;
    down_time_out = down_time_in;
    unique case (mode)
      FADE_UP: begin
        if (up_time_in >= TIMER_BITS'(FADE_UP_PERIOD)) begin
          up_time_out = '0;
          if (cur_in < saved && !ramping_down) begin
            cur_out = (up_sum > 9'(LEVEL_MAX)) ? 8'(LEVEL_MAX) : up_sum[7:0];
          end
        end
      end
      FADE_DOWN: begin
        if (down_time_in >= down_period) begin
          down_time_out = '0;
          if (cur_in != 8'd0) begin
            if (!saved_low && cur_in > 8'(LEVEL_MID)) begin
              cur_out = cur_in - 8'(FADE_DN_LARGE);
            end else begin
              cur_out = cur_in - 8'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/tilt_gesture_dimmer_unit.sv =====
// ----------------------------------------------------------------------------
// tilt_gesture_dimmer_unit
// Tilt-gesture lamp dimmer: one item per millisecond tick in, one level out.
// ----------------------------------------------------------------------------
// Usage. Each input item is one millisecond tick carrying the corrected roll
// and pitch angles, the charger status and a battery sample. An item is taken
// at a rising edge with in_valid high and in_stall low. Every item yields
// exactly one result item (led_level, lamp_on), offered on out_valid and
// taken at an edge where out_stall is low.
// The item lands in an input register; from there the whole tick update runs
// as one combinational pass into the state and result registers. Throughput
// is one item per cycle; the only limit is the single result register, so
// in_stall rises only when the input register and the result register are
// both full and the receiver stalls.
// While out_stall is held, the pending result holds its value and the block
// keeps one more item in its input register before it stalls the sender.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write them only while no
// items are in flight. Unknown indexes are ignored.
// Reset (synchronous, active high) restores the register defaults, turns the
// lamp off at level zero with saved level fifty, and empties both registers.
// ----------------------------------------------------------------------------
module tilt_gesture_dimmer_unit import tgd_pkg::*; #(
  parameter int TIMER_BITS = TGD_TIMER_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [12:0]        roll_angle,
  input  logic signed [12:0]        pitch_angle,
  input  logic                      charger_present,
  input  logic [9:0]                battery_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                led_level,
  output logic                      lamp_on,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [15:0]               cfg_data
);

  localparam int                    CW        = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  function automatic logic [TIMER_BITS-1:0] tick(input logic [TIMER_BITS-1:0] t);
    return (t == TIMER_MAX) ? TIMER_MAX : t + TIMER_BITS'(1);
  endfunction

  tgd_cfg_t cfg;

  // Input register.
  logic               s1_valid;
  logic signed [12:0] s1_roll;
  logic signed [12:0] s1_pitch;
  logic               s1_charger;
  logic [9:0]         s1_battery;
  logic               in_take;
  logic               advance;

  // Persistent state.
  tgd_state_t            st;
  logic [TIMER_BITS-1:0] roll_hold_time;
  logic [TIMER_BITS-1:0] pitch_hold_time;
  logic [TIMER_BITS-1:0] fade_up_time;
  logic [TIMER_BITS-1:0] fade_down_time;
  logic [TIMER_BITS-1:0] adjust_time;
  logic [TIMER_BITS-1:0] direction_time;

  // Timers after this tick's advance.
  logic [TIMER_BITS-1:0] t_roll;
  logic [TIMER_BITS-1:0] t_pitch;
  logic [TIMER_BITS-1:0] t_adj;
  logic [TIMER_BITS-1:0] t_dir;

  // Axis chain: roll first, then pitch sees what roll left.
  logic                  r_tilted;
  logic [TIMER_BITS-1:0] r_hold;
  tgd_dim_t              r_dim;
  logic [TIMER_BITS-1:0] r_adj;
  logic [TIMER_BITS-1:0] r_dir;
  logic                  p_tilted;
  logic [TIMER_BITS-1:0] p_hold;
  tgd_dim_t              p_dim;
  logic [TIMER_BITS-1:0] p_adj;
  logic [TIMER_BITS-1:0] p_dir;

  // State after gestures and centering, before the fade.
  tgd_state_t            mid;
  logic [TIMER_BITS-1:0] mid_roll_hold;
  logic [TIMER_BITS-1:0] mid_pitch_hold;
  logic [TIMER_BITS-1:0] mid_adj;
  logic [TIMER_BITS-1:0] mid_dir;
  tgd_fade_t             fade_mode;

  logic [7:0]            fade_level;
  logic [TIMER_BITS-1:0] fade_up_next;
  logic [TIMER_BITS-1:0] fade_down_next;
  tgd_state_t            st_next;

  // --------------------------------------------------------------------------
  // Handshake. The input register empties whenever the result register can
  // take a new value, so items flow back to back.
  // --------------------------------------------------------------------------
  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  tgd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_roll    <= roll_angle;
      s1_pitch   <= pitch_angle;
      s1_charger <= charger_present;
      s1_battery <= battery_sample;
    end
  end

  // --------------------------------------------------------------------------
  // Tick update. Every timer advances first, then the two axes run in order.
  // --------------------------------------------------------------------------
  assign t_roll  = tick(roll_hold_time);
  assign t_pitch = tick(pitch_hold_time);
  assign t_adj   = tick(adjust_time);
  assign t_dir   = tick(direction_time);

  tgd_axis #(.TIMER_BITS(TIMER_BITS)) u_roll (
    .cfg         (cfg),
    .angle       (s1_roll),
    .roll        (s1_roll),
    .pitch       (s1_pitch),
    .need_on     (1'b1),
    .dir_pos     (DIR_ROLL_POS),
    .dir_neg     (DIR_ROLL_NEG),
    .on_state    (st.on_state),
    .tilted_in   (st.roll_tilted),
    .hold_in     (t_roll),
    .dim_in      (st.dim),
    .adjust_in   (t_adj),
    .dirtime_in  (t_dir),
    .tilted_out  (r_tilted),
    .hold_out    (r_hold),
    .dim_out     (r_dim),
    .adjust_out  (r_adj),
    .dirtime_out (r_dir)
  );

  // Pitch adjusts the level even while the lamp is off.
  tgd_axis #(.TIMER_BITS(TIMER_BITS)) u_pitch (
    .cfg         (cfg),
    .angle       (s1_pitch),
    .roll        (s1_roll),
    .pitch       (s1_pitch),
    .need_on     (1'b0),
    .dir_pos     (DIR_PITCH_POS),
    .dir_neg     (DIR_PITCH_NEG),
    .on_state    (st.on_state),
    .tilted_in   (st.pitch_tilted),
    .hold_in     (t_pitch),
    .dim_in      (r_dim),
    .adjust_in   (r_adj),
    .dirtime_in  (r_dir),
    .tilted_out  (p_tilted),
    .hold_out    (p_hold),
    .dim_out     (p_dim),
    .adjust_out  (p_adj),
    .dirtime_out (p_dir)
  );

  always_comb begin
    mid            = st;
    mid_roll_hold  = t_roll;
    mid_pitch_hold = t_pitch;
    mid_adj        = t_adj;
    mid_dir        = t_dir;
    fade_mode      = FADE_NONE;
    if (s1_charger) begin
      // Plugging the charger back in arms a switch-off.
      if (st.was_unplugged) begin
        mid.was_unplugged = 1'b0;
        mid.pending_off   = 1'b1;
      end
      mid.roll_tilted  = r_tilted;
      mid.pitch_tilted = p_tilted;
      mid_roll_hold    = r_hold;
      mid_pitch_hold   = p_hold;
      mid.dim          = p_dim;
      mid_adj          = p_adj;
      mid_dir          = p_dir;

      // A fresh tilt from center switches on, or arms a switch-off if on.
      if ((mid.roll_tilted || mid.pitch_tilted) && !mid.away_from_center) begin
        if (!mid.on_state) begin
          mid.on_state         = 1'b1;
          mid.away_from_center = 1'b1;
          if (CW'(mid_dir) > CW'(cfg.direction_lock_ms)) begin
            mid.dim.last_direction = tgd_dir_pick(s1_roll, s1_pitch, cfg.tilt_trip,
                                                  mid.dim.last_direction);
            mid_dir = '0;
          end
        end else begin
          mid.pending_off      = 1'b1;
          mid.away_from_center = 1'b1;
        end
      end

      // Back at center: carry out an armed switch-off unless the level was adjusted or is ramping up.
      if (tgd_mag(s1_roll) <= {2'b00, cfg.center_band} &&
          tgd_mag(s1_pitch) <= {2'b00, cfg.center_band} && mid.away_from_center) begin
        if (mid.pending_off && !mid.dim.ramping_up && !mid.dim.level_adjusted) begin
          mid.on_state    = 1'b0;
          mid.pending_off = 1'b0;
        end
        mid.away_from_center = 1'b0;
        mid_roll_hold        = TIMER_MAX;
        mid_pitch_hold       = TIMER_MAX;
        mid.dim.ramping_up   = 1'b0;
        mid.dim.ramping_down = 1'b0;
      end

      if (mid.on_state && !mid.dim.ramping_down) begin
        fade_mode = FADE_UP;
      end else if (!mid.on_state && !mid.dim.ramping_down && !mid.dim.ramping_up &&
                   !mid.dim.level_adjusted) begin
        fade_mode = FADE_DOWN;
      end
    end else begin
      // On battery the lamp stays lit only while the battery is healthy.
      if (s1_battery > cfg.battery_ok_level) begin
        mid.away_from_center = 1'b1;
        fade_mode            = FADE_UP;
      end else begin
        fade_mode = FADE_DOWN;
      end
      mid.was_unplugged = 1'b1;
    end
  end

  tgd_fade #(.TIMER_BITS(TIMER_BITS)) u_fade (
    .mode          (fade_mode),
    .cur_in        (mid.dim.current_level),
    .saved         (mid.dim.saved_level),
    .ramping_down  (mid.dim.ramping_down),
    .up_time_in    (tick(fade_up_time)),
    .down_time_in  (tick(fade_down_time)),
    .cur_out       (fade_level),
    .up_time_out   (fade_up_next),
    .down_time_out (fade_down_next)
  );

  always_comb begin
    st_next                   = mid;
    st_next.dim.current_level = fade_level;
  end

  // --------------------------------------------------------------------------
  // State and result registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st.on_state           <= 1'b0;
      st.away_from_center   <= 1'b0;
      st.pending_off        <= 1'b0;
      st.roll_tilted        <= 1'b0;
      st.pitch_tilted       <= 1'b0;
      st.was_unplugged      <= 1'b0;
      st.dim.ramping_up     <= 1'b0;
      st.dim.ramping_down   <= 1'b0;
      st.dim.level_adjusted <= 1'b0;
      st.dim.last_direction <= DIR_NONE;
      st.dim.current_level  <= 8'd0;
      st.dim.saved_level    <= 8'(SAVED_LEVEL_RST);
      roll_hold_time        <= '0;
      pitch_hold_time       <= '0;
      fade_up_time          <= TIMER_MAX;
      fade_down_time        <= TIMER_MAX;
      adjust_time           <= TIMER_MAX;
      direction_time        <= TIMER_MAX;
    end else if (advance) begin
      st              <= st_next;
      roll_hold_time  <= mid_roll_hold;
      pitch_hold_time <= mid_pitch_hold;
      fade_up_time    <= fade_up_next;
      fade_down_time  <= fade_down_next;
      adjust_time     <= mid_adj;
      direction_time  <= mid_dir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_level <= st_next.dim.current_level;
      lamp_on   <= st_next.on_state;
    end
  end

`ifndef SYNTHESIS
  // The sender is stalled only when both registers hold items.
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid))
    else $error("in_stall raised with a free register");

  // A processed tick always produces a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed tick did not produce a result");

  // A taken result with nothing behind it leaves the output empty.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !advance) |=> !out_valid)
    else $error("result repeated after it was taken");
`endif

endmodule
